[hw/rtl/jsu_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helpers of the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

   localparam int MAX_CAPACITY = 4096;
   localparam int BYTE_W       = 8;
   localparam int CAP_W        = 13;
   localparam int LEN_W        = 12;
   localparam int HEX_W        = 16;
   localparam int KIND_W       = 2;
   localparam int CAUSE_W      = 2;
   localparam int HEX_CNT_W    = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
   localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPACITY);
   localparam logic [HEX_W-1:0] HEX_KEEP_LIMIT = HEX_W'(16'h0080);
   localparam logic [HEX_CNT_W-1:0] HEX_LAST = HEX_CNT_W'(3);

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
   localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
   localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
   localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LF_HEX = 8'h66;
   localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_IN   = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NO_QUOTE = 2'd0,
      CAUSE_NUL      = 2'd1,
      CAUSE_BAD_ESC  = 2'd2,
      CAUSE_BAD_HEX  = 2'd3
   } cause_type;

   typedef struct packed {
      logic                fire;
      kind_type            kind;
      logic [BYTE_W-1:0]   char_out;
      logic [LEN_W-1:0]    kept_length;
      cause_type           error_cause;
   } result_type;

   // {digit valid, digit value}
   function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CH_0 && c <= CH_9) begin
         r = {1'b1, 4'(c - CH_0)};
      end else if (c >= CH_LA && c <= CH_LF_HEX) begin
         r = {1'b1, 4'(c - CH_LA + 8'd10)};
      end else if (c >= CH_UA && c <= CH_UF) begin
         r = {1'b1, 4'(c - CH_UA + 8'd10)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/jsu_req_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_req_if
// Request channel: one raw text byte per request.
// ---------------------------------------------------------------------------
interface jsu_req_if;
   import jsu_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

[hw/rtl/jsu_rsp_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_rsp_if
// Result channel: decoded character, end of string or error.
// ---------------------------------------------------------------------------
interface jsu_rsp_if;
   import jsu_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [BYTE_W-1:0]  char_out;
   logic [LEN_W-1:0]   kept_length;
   logic [CAUSE_W-1:0] error_cause;

   modport source (output valid, output kind, output char_out, output kept_length,
                   output error_cause, input ready);
   modport sink   (input valid, input kind, input char_out, input kept_length,
                   input error_cause, output ready);
endinterface
`default_nettype wire

[hw/rtl/jsu_decoder.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_decoder
// Parser state and per-byte update: quote detection, escapes, hex digits and
// the saturating kept count.
// ---------------------------------------------------------------------------
module jsu_decoder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step_en,
   input  wire logic [jsu_pkg::BYTE_W-1:0] in_byte,
   input  wire logic [jsu_pkg::CAP_W-1:0]  capacity,
   output jsu_pkg::result_type            result
);
   import jsu_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HEX_CNT_W-1:0]   hex_cnt_ff, hex_cnt_in;
   logic [HEX_W-1:0]       hex_val_ff, hex_val_in;
   logic [LEN_W-1:0]       kept_ff, kept_in;

   logic [CAP_W-1:0]       cap_eff;
   logic [CAP_W-1:0]       kept_plus;
   logic [4:0]             digit;
   logic [HEX_W-1:0]       hex_shift;
   logic                   keep_req;
   logic [BYTE_W-1:0]      keep_char;
   logic                   fail_req;
   cause_type              fail_cause;
   logic                   end_req;

   assign cap_eff   = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
   assign kept_plus = {1'b0, kept_ff} + CAP_W'(1);
   assign digit     = hex_digit(in_byte);
   assign hex_shift = {hex_val_ff[HEX_W-5:0], digit[3:0]};

   always_comb begin
      phase_in   = phase_ff;
      hex_cnt_in = hex_cnt_ff;
      hex_val_in = hex_val_ff;
      kept_in    = kept_ff;
      keep_req   = 1'b0;
      keep_char  = in_byte;
      fail_req   = 1'b0;
      fail_cause = CAUSE_NO_QUOTE;
      end_req    = 1'b0;

      case (phase_ff)
         PH_WAIT: begin
            if (in_byte == CH_QUOTE) begin
               phase_in = PH_IN;
               kept_in  = '0;
            end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
                         in_byte != CH_LF && in_byte != CH_CR) begin
               kept_in    = '0;
               fail_req   = 1'b1;
               fail_cause = CAUSE_NO_QUOTE;
            end
         end
         PH_IN: begin
            if (in_byte == CH_QUOTE) begin
               end_req  = 1'b1;
               phase_in = PH_WAIT;
            end else if (in_byte == CH_NUL) begin
               fail_req   = 1'b1;
               fail_cause = CAUSE_NUL;
            end else if (in_byte == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               keep_req = 1'b1;
            end
         end
         PH_ESC: begin
            phase_in = PH_IN;
            if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
               keep_req = 1'b1;
            end else if (in_byte == CH_N) begin
               keep_req  = 1'b1;
               keep_char = CH_LF;
            end else if (in_byte == CH_T) begin
               keep_req  = 1'b1;
               keep_char = CH_TAB;
            end else if (in_byte == CH_U) begin
               phase_in   = PH_HEX;
               hex_cnt_in = '0;
               hex_val_in = '0;
            end else begin
               fail_req   = 1'b1;
               fail_cause = CAUSE_BAD_ESC;
            end
         end
         PH_HEX: begin
            if (!digit[4]) begin
               fail_req   = 1'b1;
               fail_cause = CAUSE_BAD_HEX;
            end else if (hex_cnt_ff != HEX_LAST) begin
               hex_val_in = hex_shift;
               hex_cnt_in = hex_cnt_ff + HEX_CNT_W'(1);
            end else begin
               hex_val_in = '0;
               hex_cnt_in = '0;
               phase_in   = PH_IN;
               keep_req   = (hex_shift < HEX_KEEP_LIMIT);
               keep_char  = hex_shift[BYTE_W-1:0];
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase

      if (fail_req) begin
         phase_in   = PH_WAIT;
         hex_cnt_in = '0;
         hex_val_in = '0;
      end

      result             = '0;
      result.kind        = KIND_CHAR;
      result.error_cause = CAUSE_NO_QUOTE;
      if (keep_req && kept_plus < cap_eff) begin
         kept_in          = kept_plus[LEN_W-1:0];
         result.fire      = 1'b1;
         result.char_out  = keep_char;
      end else if (end_req) begin
         result.fire = 1'b1;
         result.kind = KIND_END;
      end else if (fail_req) begin
         result.fire        = 1'b1;
         result.kind        = KIND_ERROR;
         result.error_cause = fail_cause;
      end
      result.kept_length = kept_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         hex_cnt_ff <= '0;
         hex_val_ff <= '0;
         kept_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         hex_cnt_ff <= hex_cnt_in;
         hex_val_ff <= hex_val_in;
         kept_ff    <= kept_in;
      end
   end

   // an error always returns to waiting for the opening quote
   assert property (@(posedge clock) disable iff (reset)
      step_en && result.fire && result.kind == KIND_ERROR |=> phase_ff == PH_WAIT)
      else $error("jsu_decoder: error did not return to wait");

   // a kept character advances the count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      step_en && result.fire && result.kind == KIND_CHAR |=>
      kept_ff == $past(kept_ff) + LEN_W'(1))
      else $error("jsu_decoder: kept count slip");

   // hex digit count only moves while reading hex digits
   assert property (@(posedge clock) disable iff (reset)
      hex_cnt_ff != '0 |-> phase_ff == PH_HEX)
      else $error("jsu_decoder: stray hex digit count");

   // kept count never reaches the effective capacity
   assert property (@(posedge clock) disable iff (reset)
      kept_ff != '0 |-> {1'b0, kept_ff} < cap_eff || $past(capacity) != capacity ||
      !$stable(capacity) || kept_ff == $past(kept_ff))
      else $error("jsu_decoder: kept count over capacity");
endmodule
`default_nettype wire

[hw/rtl/json_string_unescaper_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// json_string_unescaper_top
// Decodes a quoted JSON string one byte per request.
// ---------------------------------------------------------------------------
// One byte is taken every clock cycle while the result side keeps up. A byte
// passes through an input register, the parser update in jsu_decoder and a
// result register. Bytes that give no result (whitespace before the opening
// quote, the opening quote, backslash, all but the last hex digit, dropped
// characters) still move through at one per cycle while the result side
// keeps up. The per-byte parser update is the only loop. csr_wr_data sets
// the output buffer capacity (terminator included, clamped to 4096); write
// it only while no bytes are in flight.
module json_string_unescaper_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   jsu_req_if.sink                         req_ch,
   jsu_rsp_if.source                       rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [jsu_pkg::CAP_W-1:0]  csr_wr_data
);
   import jsu_pkg::*;

   logic [CAP_W-1:0]   cap_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]  s1_byte_ff;
   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  out_kind_ff;
   logic [BYTE_W-1:0]  out_char_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic [CAUSE_W-1:0] out_cause_ff;
   logic               adv;
   logic               req_take;
   result_type         result;

   assign adv      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || adv;

   assign s1_valid_in  = req_take || (s1_valid_ff && !adv);
   assign out_valid_in = adv ? result.fire : (out_valid_ff && !rsp_ch.ready);

   jsu_decoder u_decoder (
      .clock    (clock),
      .reset    (reset),
      .step_en  (adv),
      .in_byte  (s1_byte_ff),
      .capacity (cap_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_ch.in_byte;
      end
      if (adv && result.fire) begin
         out_kind_ff  <= result.kind;
         out_char_ff  <= result.char_out;
         out_len_ff   <= result.kept_length;
         out_cause_ff <= result.error_cause;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.kind        = out_kind_ff;
   assign rsp_ch.char_out    = out_char_ff;
   assign rsp_ch.kept_length = out_len_ff;
   assign rsp_ch.error_cause = out_cause_ff;

   // a request is only taken into a full input register when it drains
   assert property (@(posedge clock) disable iff (reset)
      req_take && s1_valid_ff |-> adv)
      else $error("top: input register overrun");

   // a decoded character always carries a non-zero kept length
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_CHAR |-> out_len_ff != '0)
      else $error("top: character with zero length");

   // a result register still waiting is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !adv)
      else $error("top: result overwritten while stalled");

   // only errors carry a cause
   assert property (@(posedge clock) disable iff (reset)
      adv && result.fire && result.kind != KIND_ERROR |=>
      out_cause_ff == CAUSE_W'(CAUSE_NO_QUOTE))
      else $error("top: stray error cause");
endmodule
`default_nettype wire
